[hdl/cst_pkg.sv]
// Shared types and constants for the configurable string tokenizer.
// No dependencies; cst_step and the top level in hdl/ refer to this package.
package cst_pkg;

  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int unsigned FIFO_DEPTH  = 2 * MAX_RESULTS;
  localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned ESC_W       = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PUNCT0   = 3'd0,
    CFG_PUNCT1   = 3'd1,
    CFG_PUNCT2   = 3'd2,
    CFG_PUNCT3   = 3'd3,
    CFG_QUOTE    = 3'd4,
    CFG_EXTRA_WS = 3'd5,
    CFG_ESCAPE   = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_START = 3'd0,
    ST_SKIP  = 3'd1,
    ST_UNQ   = 3'd2,
    ST_QUO   = 3'd3,
    ST_ESC   = 3'd4,
    ST_OCT   = 3'd5,
    ST_HEX   = 3'd6
  } parse_st_e;

  typedef enum logic [1:0] {
    KIND_UNQ   = 2'd0,
    KIND_QUO   = 2'd1,
    KIND_PUNCT = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_R  = 8'h72;
  localparam logic [7:0] CH_LO_T  = 8'h74;
  localparam logic [7:0] CH_LO_V  = 8'h76;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  typedef struct packed {
    logic [7:0] token_char;
    logic       has_char;
    logic       token_end;
    kind_e      token_kind;
  } res_t;

  typedef struct packed {
    parse_st_e  st;
    logic [7:0] open_quote;
    logic [7:0] esc_val;
    logic [1:0] oct_seen;
    kind_e      kind;
  } tok_state_t;

  typedef struct packed {
    logic [255:0]      punct;
    logic [63:0]       quotes;
    logic [63:0]       extra_ws;
    logic [ESC_W-1:0]  esc;
  } cfg_t;

  function automatic res_t mk_res(logic [7:0] ch, logic has, logic fin, kind_e kind);
    res_t r;
    r.token_char = ch;
    r.has_char   = has;
    r.token_end  = fin;
    r.token_kind = kind;
    return r;
  endfunction

endpackage

[hdl/cst_channels.sv]
// Valid/ready channel interfaces for the tokenizer's byte input and result output.
// Depends on nothing; payload names follow the item fields.
interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_input;

  modport source (output valid, output byte_in, output end_of_input, input ready);
  modport sink   (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface cst_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_char;
  logic       has_char;
  logic       token_end;
  logic [1:0] token_kind;

  modport source (output valid, output token_char, output has_char, output token_end,
                  output token_kind, input ready);
  modport sink   (input valid, input token_char, input has_char, input token_end,
                  input token_kind, output ready);
endinterface

[hdl/cst_step.sv]
// Next-state and result logic for one input byte of the tokenizer.
// Depends on cst_pkg; purely combinational, registered by the top level.
module cst_step #(
  parameter int unsigned QUOTE_SLOTS      = 8,
  parameter int unsigned WHITESPACE_SLOTS = 8
) (
  input  cst_pkg::cfg_t                              cfg_i,
  input  cst_pkg::tok_state_t                        cur_i,
  input  logic [7:0]                                 byte_i,
  input  logic                                       eoi_i,
  output cst_pkg::tok_state_t                        nxt_o,
  output cst_pkg::res_t [cst_pkg::MAX_RESULTS-1:0]   res_o,
  output logic [cst_pkg::RES_CNT_W-1:0]              n_o
);

  localparam logic [cst_pkg::RES_CNT_W-1:0] RES_ONE = cst_pkg::RES_CNT_W'(1);

  logic       is_quote, is_punct, is_ws, is_esc, base_ws, extra_ws, cont_run;
  logic       is_oct, is_hex;
  logic [3:0] hex_d;

  // character classes
  always_comb begin
    is_quote = 1'b0;
    extra_ws = 1'b0;
    for (int i = 0; i < QUOTE_SLOTS; i++) begin
      if (cfg_i.quotes[8*i +: 8] != cst_pkg::CH_NUL && cfg_i.quotes[8*i +: 8] == byte_i) begin
        is_quote = 1'b1;
      end
    end
    for (int i = 0; i < WHITESPACE_SLOTS; i++) begin
      if (cfg_i.extra_ws[8*i +: 8] != cst_pkg::CH_NUL &&
          cfg_i.extra_ws[8*i +: 8] == byte_i) begin
        extra_ws = 1'b1;
      end
    end
    is_punct = cfg_i.punct[byte_i];
    is_esc   = !cfg_i.esc[cst_pkg::ESC_W-1] && (cfg_i.esc[7:0] == byte_i);
    base_ws  = byte_i inside {cst_pkg::CH_NUL, cst_pkg::CH_SPACE,
                              [cst_pkg::CH_TAB:cst_pkg::CH_CR]};
    is_ws    = (base_ws || extra_ws) && !is_esc && !is_quote && !is_punct;
    cont_run = is_esc || (!is_quote && !is_punct && !is_ws);
    is_oct   = byte_i inside {[cst_pkg::CH_ZERO:cst_pkg::CH_SEVEN]};
    is_hex   = 1'b1;
    hex_d    = byte_i[3:0];
    if (byte_i inside {[cst_pkg::CH_ZERO:cst_pkg::CH_NINE]}) begin
      hex_d = byte_i[3:0];
    end else if (byte_i inside {[cst_pkg::CH_UP_A:cst_pkg::CH_UP_F],
                                [cst_pkg::CH_LO_A:cst_pkg::CH_LO_F]}) begin
      hex_d = byte_i[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    cst_pkg::tok_state_t              nx;
    cst_pkg::res_t [cst_pkg::MAX_RESULTS-1:0] rs;
    logic [cst_pkg::RES_CNT_W-1:0]    n;
    logic                             do_tok, do_btw;
    logic [7:0]                       lit;

    nx     = cur_i;
    rs     = '0;
    n      = '0;
    do_tok = 1'b0;
    do_btw = 1'b0;
    lit    = byte_i;

    if (eoi_i) begin
      case (cur_i.st)
        cst_pkg::ST_UNQ, cst_pkg::ST_QUO: begin
          rs[n[1:0]] = cst_pkg::mk_res(8'h00, 1'b0, 1'b1, cur_i.kind);
          n = n + RES_ONE;
        end
        cst_pkg::ST_ESC: begin
          rs[n[1:0]] = cst_pkg::mk_res(cfg_i.esc[7:0], 1'b1, 1'b0, cur_i.kind);
          n = n + RES_ONE;
          rs[n[1:0]] = cst_pkg::mk_res(8'h00, 1'b0, 1'b1, cur_i.kind);
          n = n + RES_ONE;
        end
        cst_pkg::ST_OCT, cst_pkg::ST_HEX: begin
          rs[n[1:0]] = cst_pkg::mk_res(cur_i.esc_val, 1'b1, 1'b0, cur_i.kind);
          n = n + RES_ONE;
          rs[n[1:0]] = cst_pkg::mk_res(8'h00, 1'b0, 1'b1, cur_i.kind);
          n = n + RES_ONE;
        end
        default: ;
      endcase
      nx.st         = cst_pkg::ST_START;
      nx.open_quote = '0;
      nx.esc_val    = '0;
      nx.oct_seen   = '0;
      nx.kind       = cst_pkg::KIND_UNQ;
    end else begin
      case (cur_i.st)
        cst_pkg::ST_START: begin
          if (is_ws) begin
            rs[n[1:0]] = cst_pkg::mk_res(8'h00, 1'b0, 1'b1, cst_pkg::KIND_EMPTY);
            n = n + RES_ONE;
            nx.st = cst_pkg::ST_SKIP;
          end else begin
            do_btw = 1'b1;
          end
        end
        cst_pkg::ST_UNQ, cst_pkg::ST_QUO: do_tok = 1'b1;
        cst_pkg::ST_ESC: begin
          if (is_oct) begin
            nx.esc_val  = {5'd0, byte_i[2:0]};
            nx.oct_seen = 2'd1;
            nx.st       = cst_pkg::ST_OCT;
          end else if (byte_i == cst_pkg::CH_LO_X) begin
            nx.esc_val = '0;
            nx.st      = cst_pkg::ST_HEX;
          end else begin
            case (byte_i)
              cst_pkg::CH_LO_A: lit = cst_pkg::CH_BEL;
              cst_pkg::CH_LO_B: lit = cst_pkg::CH_BS;
              cst_pkg::CH_LO_F: lit = cst_pkg::CH_FF;
              cst_pkg::CH_LO_N: lit = cst_pkg::CH_NL;
              cst_pkg::CH_LO_R: lit = cst_pkg::CH_CR;
              cst_pkg::CH_LO_T: lit = cst_pkg::CH_TAB;
              cst_pkg::CH_LO_V: lit = cst_pkg::CH_VT;
              default:          lit = byte_i;
            endcase
            rs[n[1:0]] = cst_pkg::mk_res(lit, 1'b1, 1'b0, cur_i.kind);
            n = n + RES_ONE;
            nx.st = (cur_i.kind == cst_pkg::KIND_QUO) ? cst_pkg::ST_QUO : cst_pkg::ST_UNQ;
          end
        end
        cst_pkg::ST_OCT: begin
          if (is_oct) begin
            nx.esc_val  = {cur_i.esc_val[4:0], byte_i[2:0]};
            nx.oct_seen = cur_i.oct_seen + 2'd1;
            if (nx.oct_seen == 2'd3) begin
              rs[n[1:0]] = cst_pkg::mk_res(nx.esc_val, 1'b1, 1'b0, cur_i.kind);
              n = n + RES_ONE;
              nx.oct_seen = '0;
              nx.st = (cur_i.kind == cst_pkg::KIND_QUO) ? cst_pkg::ST_QUO : cst_pkg::ST_UNQ;
            end
          end else begin
            rs[n[1:0]] = cst_pkg::mk_res(cur_i.esc_val, 1'b1, 1'b0, cur_i.kind);
            n = n + RES_ONE;
            nx.oct_seen = '0;
            nx.st = (cur_i.kind == cst_pkg::KIND_QUO) ? cst_pkg::ST_QUO : cst_pkg::ST_UNQ;
            do_tok = 1'b1;
          end
        end
        cst_pkg::ST_HEX: begin
          if (is_hex) begin
            nx.esc_val = {cur_i.esc_val[3:0], hex_d};
          end else begin
            rs[n[1:0]] = cst_pkg::mk_res(cur_i.esc_val, 1'b1, 1'b0, cur_i.kind);
            n = n + RES_ONE;
            nx.st = (cur_i.kind == cst_pkg::KIND_QUO) ? cst_pkg::ST_QUO : cst_pkg::ST_UNQ;
            do_tok = 1'b1;
          end
        end
        default: begin
          if (!is_ws) do_btw = 1'b1;
          else nx.st = cst_pkg::ST_SKIP;
        end
      endcase

      // byte inside an open token; may close it and fall through to between-token handling
      if (do_tok) begin
        if (cur_i.kind == cst_pkg::KIND_QUO) begin
          if (byte_i == cur_i.open_quote) begin
            rs[n[1:0]] = cst_pkg::mk_res(8'h00, 1'b0, 1'b1, cur_i.kind);
            n = n + RES_ONE;
            nx.st = cst_pkg::ST_SKIP;
          end else if (byte_i == cst_pkg::CH_NL && !is_esc) begin
            rs[n[1:0]] = cst_pkg::mk_res(8'h00, 1'b0, 1'b1, cur_i.kind);
            n = n + RES_ONE;
            do_btw = 1'b1;
          end else if (is_esc) begin
            nx.st = cst_pkg::ST_ESC;
          end else begin
            rs[n[1:0]] = cst_pkg::mk_res(byte_i, 1'b1, 1'b0, cst_pkg::KIND_QUO);
            n = n + RES_ONE;
          end
        end else begin
          if (!cont_run) begin
            rs[n[1:0]] = cst_pkg::mk_res(8'h00, 1'b0, 1'b1, cur_i.kind);
            n = n + RES_ONE;
            do_btw = 1'b1;
          end else if (is_esc) begin
            nx.st = cst_pkg::ST_ESC;
          end else begin
            rs[n[1:0]] = cst_pkg::mk_res(byte_i, 1'b1, 1'b0, cst_pkg::KIND_UNQ);
            n = n + RES_ONE;
          end
        end
      end

      if (do_btw) begin
        if (is_quote) begin
          nx.open_quote = byte_i;
          nx.kind       = cst_pkg::KIND_QUO;
          nx.st         = cst_pkg::ST_QUO;
        end else if (is_punct) begin
          rs[n[1:0]] = cst_pkg::mk_res(byte_i, 1'b1, 1'b0, cst_pkg::KIND_PUNCT);
          n = n + RES_ONE;
          rs[n[1:0]] = cst_pkg::mk_res(8'h00, 1'b0, 1'b1, cst_pkg::KIND_PUNCT);
          n = n + RES_ONE;
          nx.st = cst_pkg::ST_SKIP;
        end else if (!is_ws) begin
          nx.kind = cst_pkg::KIND_UNQ;
          if (is_esc) begin
            nx.st = cst_pkg::ST_ESC;
          end else begin
            rs[n[1:0]] = cst_pkg::mk_res(byte_i, 1'b1, 1'b0, cst_pkg::KIND_UNQ);
            n = n + RES_ONE;
            nx.st = cst_pkg::ST_UNQ;
          end
        end else begin
          nx.st = cst_pkg::ST_SKIP;
        end
      end
    end

    nxt_o = nx;
    res_o = rs;
    n_o   = n;
  end

endmodule

[hdl/configurable_string_tokenizer_unit.sv]
// Top level of the configurable string tokenizer: config registers, parse state, result queue.
// Depends on cst_pkg, cst_channels (cst_in_if, cst_out_if) and cst_step.
//
// Usage:
//   in_i carries one raw byte per item (byte_in), or an end-of-stream mark
//   (end_of_input = 1, byte_in ignored). out_o carries decoded token bytes
//   and end-of-token markers, one result per item, in stream order.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   the block is idle; indexes 0..3 punctuation masks, 4 quote slots,
//   5 extra whitespace slots, 6 escape byte (9 bits, 256 = none).
// Timing:
//   An accepted byte is decoded in the cycle it is taken and its results
//   (zero to four) land in an eight-entry result queue; if the queue was empty,
//   the first one is on out_o in the cycle after acceptance. One byte per cycle
//   is accepted as long as the queue holds at most four results, so a steady
//   stream that gives one result per byte runs at one byte per cycle; a byte
//   with several results leaves the extra ones to drain from the queue head in turn.
// Reset:
//   rst_ni clears the parse state to start of stream, empties the queue and
//   restores the register defaults. When the receiver stalls, results wait
//   in the queue and in_i.ready drops once fewer than four entries are free.
module configurable_string_tokenizer_unit #(
  parameter int unsigned QUOTE_SLOTS      = 8,
  parameter int unsigned WHITESPACE_SLOTS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  cst_in_if.sink                             in_i,
  cst_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [cst_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cst_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [3:0][63:0]               punct_q;
  logic [63:0]                    quote_q;
  logic [63:0]                    extra_ws_q;
  logic [cst_pkg::ESC_W-1:0]      esc_q;
  cst_pkg::cfg_t                  cfg;

  cst_pkg::tok_state_t            state_q, state_d;
  cst_pkg::res_t [cst_pkg::MAX_RESULTS-1:0] res;
  logic [cst_pkg::RES_CNT_W-1:0]  res_n;

  cst_pkg::res_t [cst_pkg::FIFO_DEPTH-1:0] fifo_q;
  logic [cst_pkg::FIFO_AW-1:0]    head_q, tail_q;
  logic [cst_pkg::FIFO_AW:0]      count_q, count_d;
  logic                           in_fire, out_fire;
  logic [cst_pkg::RES_CNT_W-1:0]  push_n;

  assign cfg.punct    = punct_q;
  assign cfg.quotes   = quote_q;
  assign cfg.extra_ws = extra_ws_q;
  assign cfg.esc      = esc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      punct_q    <= '0;
      quote_q    <= '0;
      extra_ws_q <= '0;
      esc_q      <= cst_pkg::ESC_W'(256);
    end else if (cfg_we_i) begin
      case (cst_pkg::cfg_idx_e'(cfg_idx_i))
        cst_pkg::CFG_PUNCT0,
        cst_pkg::CFG_PUNCT1,
        cst_pkg::CFG_PUNCT2,
        cst_pkg::CFG_PUNCT3:   punct_q[cfg_idx_i[1:0]] <= cfg_data_i;
        cst_pkg::CFG_QUOTE:    quote_q    <= cfg_data_i;
        cst_pkg::CFG_EXTRA_WS: extra_ws_q <= cfg_data_i;
        cst_pkg::CFG_ESCAPE:   esc_q      <= cfg_data_i[cst_pkg::ESC_W-1:0];
        default: ;
      endcase
    end
  end

  cst_step #(
    .QUOTE_SLOTS      (QUOTE_SLOTS),
    .WHITESPACE_SLOTS (WHITESPACE_SLOTS)
  ) u_step (
    .cfg_i  (cfg),
    .cur_i  (state_q),
    .byte_i (in_i.byte_in),
    .eoi_i  (in_i.end_of_input),
    .nxt_o  (state_d),
    .res_o  (res),
    .n_o    (res_n)
  );

  // room for a full burst of results must be free before taking a byte
  assign in_i.ready = (count_q <= (cst_pkg::FIFO_AW + 1)'(cst_pkg::FIFO_DEPTH -
                                                         cst_pkg::MAX_RESULTS));
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;
  assign push_n     = in_fire ? res_n : '0;
  assign count_d    = count_q + (cst_pkg::FIFO_AW + 1)'(push_n)
                    - (cst_pkg::FIFO_AW + 1)'(out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (in_fire) state_q <= state_d;
      tail_q  <= tail_q + cst_pkg::FIFO_AW'(push_n);
      if (out_fire) head_q <= head_q + cst_pkg::FIFO_AW'(1);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < cst_pkg::MAX_RESULTS; i++) begin
      if (cst_pkg::RES_CNT_W'(i) < push_n) begin
        fifo_q[tail_q + cst_pkg::FIFO_AW'(i)] <= res[i];
      end
    end
  end

  assign out_o.valid      = (count_q != '0);
  assign out_o.token_char = fifo_q[head_q].token_char;
  assign out_o.has_char   = fifo_q[head_q].has_char;
  assign out_o.token_end  = fifo_q[head_q].token_end;
  assign out_o.token_kind = fifo_q[head_q].token_kind;

`ifndef NO_ASSERTIONS
  a_room_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (count_q <= (cst_pkg::FIFO_AW + 1)'(cst_pkg::FIFO_DEPTH - cst_pkg::MAX_RESULTS)))
    else $error("byte accepted without room for its results");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (cst_pkg::FIFO_AW + 1)'(cst_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == (cst_pkg::FIFO_AW + 1)'(cst_pkg::FIFO_DEPTH)) ||
    ((tail_q - head_q) == count_q[cst_pkg::FIFO_AW-1:0]))
    else $error("queue pointers disagree with count");

  a_eoi_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.end_of_input) |=> (state_q.st == cst_pkg::ST_START))
    else $error("parser not back at stream start after end of input");
`endif

endmodule

[test/tb_top.sv]
// Self-checking testbench for configurable_string_tokenizer_unit.
// Depends on cst_pkg and the cst_in_if / cst_out_if channel interfaces; a built-in
// tokenizer predictor checks every result item against its expected value.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [cst_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam logic [cst_pkg::ESC_W-1:0]     ESC_NONE       = 9'h100;
  localparam int                            STALL_LIMIT    = 5000;
  localparam int                            SETTLE_CYCLES  = 12;
  localparam int                            BURST_BYTES    = 86;

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    bit         drain_first;
  } byte_item_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [cst_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [cst_pkg::CFG_DATA_W-1:0] cfg_data;

  cst_in_if  in_ch ();
  cst_out_if out_ch ();

  configurable_string_tokenizer_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  byte_item_t     feed_q[$];
  cst_pkg::res_t  due_results[$];
  int             mismatches;
  int             stall_cycles;
  int             send_gap_pct;
  int             recv_stall_pct;
  logic           in_took;

  // Predictor copy of the registers and parse state
  logic [255:0]              punct_flags;
  logic [63:0]               quote_slots;
  logic [63:0]               extra_ws_slots;
  logic [cst_pkg::ESC_W-1:0] esc_code;
  cst_pkg::parse_st_e        pst      = cst_pkg::ST_START;
  logic [7:0]                open_q   = cst_pkg::CH_NUL;
  logic [7:0]                esc_acc  = cst_pkg::CH_NUL;
  logic [1:0]                oct_cnt  = 2'd0;
  cst_pkg::kind_e            cur_kind = cst_pkg::KIND_UNQ;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit in_slots(logic [63:0] slots, logic [7:0] c);
    for (int i = 0; i < 8; i++) begin
      if (slots[8*i +: 8] != cst_pkg::CH_NUL && slots[8*i +: 8] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit is_esc_byte(logic [7:0] c);
    return esc_code < ESC_NONE && c == esc_code[7:0];
  endfunction

  function automatic bit is_quote_byte(logic [7:0] c);
    return in_slots(quote_slots, c);
  endfunction

  function automatic bit is_punct_byte(logic [7:0] c);
    return punct_flags[c];
  endfunction

  function automatic bit is_ws_byte(logic [7:0] c);
    bit w;
    w = c == cst_pkg::CH_NUL || (c >= cst_pkg::CH_TAB && c <= cst_pkg::CH_CR) ||
        c == cst_pkg::CH_SPACE || in_slots(extra_ws_slots, c);
    return w && !is_esc_byte(c) && !is_quote_byte(c) && !is_punct_byte(c);
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= cst_pkg::CH_ZERO && c <= cst_pkg::CH_NINE) return int'(c - cst_pkg::CH_ZERO);
    if (c >= cst_pkg::CH_UP_A && c <= cst_pkg::CH_UP_F) return int'(c - cst_pkg::CH_UP_A) + 10;
    if (c >= cst_pkg::CH_LO_A && c <= cst_pkg::CH_LO_F) return int'(c - cst_pkg::CH_LO_A) + 10;
    return -1;
  endfunction

  task automatic emit_res(logic [7:0] ch, logic has, logic fin, cst_pkg::kind_e kind);
    cst_pkg::res_t r;
    r.token_char = ch;
    r.has_char   = has;
    r.token_end  = fin;
    r.token_kind = kind;
    due_results = {due_results, r};
  endtask

  task automatic close_token();
    emit_res(cst_pkg::CH_NUL, 1'b0, 1'b1, cur_kind);
  endtask

  task automatic resume_token();
    pst = (cur_kind == cst_pkg::KIND_QUO) ? cst_pkg::ST_QUO : cst_pkg::ST_UNQ;
  endtask

  task automatic start_between(logic [7:0] c);
    if (is_quote_byte(c)) begin
      open_q   = c;
      cur_kind = cst_pkg::KIND_QUO;
      pst      = cst_pkg::ST_QUO;
    end else if (is_punct_byte(c)) begin
      emit_res(c, 1'b1, 1'b0, cst_pkg::KIND_PUNCT);
      emit_res(cst_pkg::CH_NUL, 1'b0, 1'b1, cst_pkg::KIND_PUNCT);
      pst = cst_pkg::ST_SKIP;
    end else if (!is_ws_byte(c)) begin
      cur_kind = cst_pkg::KIND_UNQ;
      if (is_esc_byte(c)) begin
        pst = cst_pkg::ST_ESC;
      end else begin
        emit_res(c, 1'b1, 1'b0, cst_pkg::KIND_UNQ);
        pst = cst_pkg::ST_UNQ;
      end
    end else begin
      pst = cst_pkg::ST_SKIP;
    end
  endtask

  task automatic token_byte(logic [7:0] c);
    if (cur_kind == cst_pkg::KIND_QUO) begin
      if (c == open_q) begin
        close_token();
        pst = cst_pkg::ST_SKIP;
      end else if (c == cst_pkg::CH_NL && !is_esc_byte(c)) begin
        // newline closes the quoted token and is then handled on its own
        close_token();
        start_between(c);
      end else if (is_esc_byte(c)) begin
        pst = cst_pkg::ST_ESC;
      end else begin
        emit_res(c, 1'b1, 1'b0, cst_pkg::KIND_QUO);
      end
    end else begin
      if (!(is_esc_byte(c) || (!is_quote_byte(c) && !is_punct_byte(c) && !is_ws_byte(c))))
      begin
        close_token();
        start_between(c);
      end else if (is_esc_byte(c)) begin
        pst = cst_pkg::ST_ESC;
      end else begin
        emit_res(c, 1'b1, 1'b0, cst_pkg::KIND_UNQ);
      end
    end
  endtask

  task automatic escape_letter(logic [7:0] c);
    logic [7:0] r;
    if (c >= cst_pkg::CH_ZERO && c <= cst_pkg::CH_SEVEN) begin
      esc_acc = c - cst_pkg::CH_ZERO;
      oct_cnt = 2'd1;
      pst     = cst_pkg::ST_OCT;
      return;
    end
    if (c == cst_pkg::CH_LO_X) begin
      esc_acc = cst_pkg::CH_NUL;
      pst     = cst_pkg::ST_HEX;
      return;
    end
    case (c)
      cst_pkg::CH_LO_A: r = cst_pkg::CH_BEL;
      cst_pkg::CH_LO_B: r = cst_pkg::CH_BS;
      cst_pkg::CH_LO_F: r = cst_pkg::CH_FF;
      cst_pkg::CH_LO_N: r = cst_pkg::CH_NL;
      cst_pkg::CH_LO_R: r = cst_pkg::CH_CR;
      cst_pkg::CH_LO_T: r = cst_pkg::CH_TAB;
      cst_pkg::CH_LO_V: r = cst_pkg::CH_VT;
      default: r = c;
    endcase
    emit_res(r, 1'b1, 1'b0, cur_kind);
    resume_token();
  endtask

  task automatic tokenize_item(logic [7:0] c, logic eoi);
    int d;
    if (eoi) begin
      case (pst)
        cst_pkg::ST_UNQ, cst_pkg::ST_QUO: close_token();
        cst_pkg::ST_ESC: begin
          emit_res(esc_code[7:0], 1'b1, 1'b0, cur_kind);
          close_token();
        end
        cst_pkg::ST_OCT, cst_pkg::ST_HEX: begin
          emit_res(esc_acc, 1'b1, 1'b0, cur_kind);
          close_token();
        end
        default: ;
      endcase
      pst      = cst_pkg::ST_START;
      open_q   = cst_pkg::CH_NUL;
      esc_acc  = cst_pkg::CH_NUL;
      oct_cnt  = 2'd0;
      cur_kind = cst_pkg::KIND_UNQ;
      return;
    end
    case (pst)
      cst_pkg::ST_START: begin
        if (is_ws_byte(c)) begin
          emit_res(cst_pkg::CH_NUL, 1'b0, 1'b1, cst_pkg::KIND_EMPTY);
          pst = cst_pkg::ST_SKIP;
        end else begin
          start_between(c);
        end
      end
      cst_pkg::ST_UNQ, cst_pkg::ST_QUO: token_byte(c);
      cst_pkg::ST_ESC: escape_letter(c);
      cst_pkg::ST_OCT: begin
        if (c >= cst_pkg::CH_ZERO && c <= cst_pkg::CH_SEVEN) begin
          esc_acc = {esc_acc[4:0], 3'b000} + (c - cst_pkg::CH_ZERO);
          oct_cnt = oct_cnt + 2'd1;
          if (oct_cnt == 2'd3) begin
            emit_res(esc_acc, 1'b1, 1'b0, cur_kind);
            oct_cnt = 2'd0;
            resume_token();
          end
        end else begin
          emit_res(esc_acc, 1'b1, 1'b0, cur_kind);
          oct_cnt = 2'd0;
          resume_token();
          token_byte(c);
        end
      end
      cst_pkg::ST_HEX: begin
        d = hex_digit(c);
        if (d >= 0) begin
          esc_acc = {esc_acc[3:0], 4'(d)};
        end else begin
          emit_res(esc_acc, 1'b1, 1'b0, cur_kind);
          resume_token();
          token_byte(c);
        end
      end
      default: begin
        if (!is_ws_byte(c)) start_between(c);
        else pst = cst_pkg::ST_SKIP;
      end
    endcase
  endtask

  task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
    end
  endtask

  // Sample both channels, score results, and feed accepted bytes to the predictor
  always @(posedge clk_i) begin
    cst_pkg::res_t want;
    in_took <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got char %0h has %0b end %0b kind %0d",
                 $time, out_ch.token_char, out_ch.has_char, out_ch.token_end,
                 out_ch.token_kind);
      end else begin
        want = due_results.pop_front();
        check_field("token_char", want.token_char, out_ch.token_char);
        check_field("has_char", 8'(want.has_char), 8'(out_ch.has_char));
        check_field("token_end", 8'(want.token_end), 8'(out_ch.token_end));
        check_field("token_kind", 8'(want.token_kind), 8'(out_ch.token_kind));
      end
    end
    if (rst_ni && in_ch.valid && in_ch.ready) tokenize_item(in_ch.byte_in, in_ch.end_of_input);
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (feed_q.size() == 0 && !in_ch.valid && due_results.size() == 0))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  // Byte driver and result-side stall
  always @(negedge clk_i) begin
    byte_item_t nxt;
    if (!rst_ni) begin
      in_ch.valid        <= 1'b0;
      in_ch.byte_in      <= cst_pkg::CH_NUL;
      in_ch.end_of_input <= 1'b0;
      out_ch.ready       <= 1'b0;
    end else begin
      if (!in_ch.valid || in_took) begin
        if (feed_q.size() != 0 && $urandom_range(99) >= send_gap_pct &&
            !(feed_q[0].drain_first && due_results.size() != 0)) begin
          nxt = feed_q.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.byte_in      <= nxt.ch;
          in_ch.end_of_input <= nxt.eoi;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("tb_top NOT OK");
    $finish;
  end

  task automatic queue_item(logic [7:0] ch, logic eoi, bit drain);
    byte_item_t it;
    it.ch          = ch;
    it.eoi         = eoi;
    it.drain_first = drain;
    feed_q = {feed_q, it};
  endtask

  task automatic queue_byte(logic [7:0] ch);
    queue_item(ch, 1'b0, $urandom_range(49) == 0);
  endtask

  task automatic queue_eoi();
    // hold end of stream until everything before it has drained now and then
    queue_item(8'($urandom()), 1'b1, $urandom_range(9) == 0);
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  task automatic set_reg(logic [cst_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    case (idx)
      cst_pkg::CFG_PUNCT0:   punct_flags[63:0]    = data;
      cst_pkg::CFG_PUNCT1:   punct_flags[127:64]  = data;
      cst_pkg::CFG_PUNCT2:   punct_flags[191:128] = data;
      cst_pkg::CFG_PUNCT3:   punct_flags[255:192] = data;
      cst_pkg::CFG_QUOTE:    quote_slots          = data;
      cst_pkg::CFG_EXTRA_WS: extra_ws_slots       = data;
      cst_pkg::CFG_ESCAPE:   esc_code             = data[cst_pkg::ESC_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic write_punct(logic [255:0] flags);
    set_reg(cst_pkg::CFG_PUNCT0, flags[63:0]);
    set_reg(cst_pkg::CFG_PUNCT1, flags[127:64]);
    set_reg(cst_pkg::CFG_PUNCT2, flags[191:128]);
    set_reg(cst_pkg::CFG_PUNCT3, flags[255:192]);
  endtask

  task automatic apply_setting(int k);
    logic [255:0] flags;
    logic [63:0]  slots;
    flags = '0;
    case (k)
      0: begin
        // C-like: ( ) , ; = { } as punctuation, double and single quote, backslash escape
        flags[8'h28] = 1'b1; flags[8'h29] = 1'b1; flags[8'h2C] = 1'b1;
        flags[8'h3B] = 1'b1; flags[8'h3D] = 1'b1; flags[8'h7B] = 1'b1;
        flags[8'h7D] = 1'b1;
        write_punct(flags);
        set_reg(cst_pkg::CFG_QUOTE, 64'h2722);
        set_reg(cst_pkg::CFG_EXTRA_WS, 64'h7C00);
        set_reg(cst_pkg::CFG_ESCAPE, 64'h05C);
      end
      1: begin
        write_punct(flags);
        set_reg(cst_pkg::CFG_QUOTE, 64'h0);
        set_reg(cst_pkg::CFG_EXTRA_WS, 64'h0);
        set_reg(cst_pkg::CFG_ESCAPE, 64'(ESC_NONE));
        set_reg(CFG_IDX_UNUSED, {$urandom(), $urandom()});
      end
      2: begin
        write_punct('1);
        set_reg(cst_pkg::CFG_QUOTE, '1);
        set_reg(cst_pkg::CFG_EXTRA_WS, '1);
        set_reg(cst_pkg::CFG_ESCAPE, 64'h000);
      end
      3: begin
        for (int i = 0; i < 8; i++) flags[32*i +: 32] = $urandom() & $urandom() & $urandom();
        write_punct(flags);
        for (int i = 0; i < 8; i++)
          slots[8*i +: 8] = ($urandom_range(2) == 0) ? cst_pkg::CH_NUL : 8'($urandom());
        set_reg(cst_pkg::CFG_QUOTE, slots);
        set_reg(cst_pkg::CFG_EXTRA_WS, {$urandom(), $urandom()});
        set_reg(cst_pkg::CFG_ESCAPE,
                ($urandom_range(3) == 0) ? 64'h1FF : 64'($urandom_range(255)));
      end
      default: begin
        // newline as escape byte, parentheses and bytes 0x80 and 0xFF as punctuation
        flags[8'h28] = 1'b1; flags[8'h29] = 1'b1; flags[8'h80] = 1'b1;
        flags[8'hFF] = 1'b1;
        write_punct(flags);
        set_reg(cst_pkg::CFG_QUOTE, 64'h2300_0000_0000_0022);
        set_reg(cst_pkg::CFG_EXTRA_WS, 64'h5F00_0000_0000_0000);
        set_reg(cst_pkg::CFG_ESCAPE, 64'(cst_pkg::CH_NL));
      end
    endcase
  endtask

  function automatic logic [7:0] word_byte();
    string alpha = "abcdefxyz019AFG_.";
    if ($urandom_range(3) == 0) return 8'($urandom_range(126, 33));
    return alpha[$urandom_range(alpha.len() - 1)];
  endfunction

  function automatic logic [7:0] quote_byte();
    logic [7:0] picks[$];
    for (int i = 0; i < 8; i++)
      if (quote_slots[8*i +: 8] != cst_pkg::CH_NUL) picks = {picks, quote_slots[8*i +: 8]};
    if (picks.size() == 0) return 8'($urandom());
    return picks[$urandom_range(picks.size() - 1)];
  endfunction

  function automatic logic [7:0] punct_byte();
    logic [7:0] c;
    c = 8'($urandom());
    for (int i = 0; i < 32 && !punct_flags[c]; i++) c = 8'($urandom());
    return c;
  endfunction

  function automatic logic [7:0] space_byte();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return cst_pkg::CH_NUL;
    if (sel == 6) return cst_pkg::CH_SPACE;
    if (sel == 7) return extra_ws_slots[8*$urandom_range(7) +: 8];
    return cst_pkg::CH_TAB + 8'(sel - 1);
  endfunction

  task automatic queue_escape();
    string letters = "abfnrtvqz\"\n";
    string hexd = "0123456789abcdefABCDEF";
    if (esc_code >= ESC_NONE) return;
    queue_byte(esc_code[7:0]);
    case ($urandom_range(3))
      0: queue_byte(letters[$urandom_range(letters.len() - 1)]);
      1: begin
        queue_byte(cst_pkg::CH_LO_X);
        repeat ($urandom_range(3)) queue_byte(hexd[$urandom_range(hexd.len() - 1)]);
      end
      2: repeat ($urandom_range(4, 1)) queue_byte(cst_pkg::CH_ZERO + 8'($urandom_range(7)));
      default: queue_byte(8'($urandom()));
    endcase
  endtask

  task automatic queue_burst(int n);
    int start;
    int pick;
    logic [7:0] q;
    start = feed_q.size();
    while (feed_q.size() - start < n) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        repeat ($urandom_range(5, 1)) begin
          if ($urandom_range(5) == 0) queue_escape();
          else queue_byte(word_byte());
        end
      end else if (pick < 45) begin
        q = quote_byte();
        queue_byte(q);
        repeat ($urandom_range(5)) begin
          if ($urandom_range(4) == 0) queue_escape();
          else queue_byte(($urandom_range(3) == 0) ? 8'($urandom()) : word_byte());
        end
        case ($urandom_range(9))
          0: queue_byte(cst_pkg::CH_NL);
          1: ;
          default: queue_byte(q);
        endcase
      end else if (pick < 55) begin
        queue_byte(punct_byte());
      end else if (pick < 70) begin
        repeat ($urandom_range(3, 1)) queue_byte(space_byte());
      end else if (pick < 80) begin
        queue_escape();
      end else if (pick < 85) begin
        queue_eoi();
      end else begin
        queue_byte(8'($urandom()));
      end
    end
  endtask

  task automatic wait_idle();
    while (!(feed_q.size() == 0 && !in_ch.valid && due_results.size() == 0))
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    cfg_we             = 1'b0;
    cfg_idx            = cst_pkg::CFG_PUNCT0;
    cfg_data           = '0;
    send_gap_pct       = 0;
    recv_stall_pct     = 0;
    punct_flags        = '0;
    quote_slots        = '0;
    extra_ws_slots     = '0;
    esc_code           = ESC_NONE;
    rst_ni             = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < 5; p++) begin
      apply_setting(p);
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 47; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 47; end
        default: begin send_gap_pct = 29; recv_stall_pct = 29; end
      endcase
      if (p == 0) begin
        // leading blank, hex escapes, bare \x, punctuation ending a run, quoted NUL and 0xFF,
        // three-digit octal, pass-through escape, newline ending a quote, escape at end,
        // octal run at end
        queue_text(" ab\\x41\\xz(\"");
        queue_byte(cst_pkg::CH_NUL);
        queue_byte(8'hFF);
        queue_text("\\1234\\q\n|'\\");
        queue_item(cst_pkg::CH_NUL, 1'b1, 1'b1);
        queue_text("w\\7");
        queue_item(8'hFF, 1'b1, 1'b0);
      end
      queue_burst(BURST_BYTES);
      wait_idle();
    end
    queue_item(cst_pkg::CH_NUL, 1'b1, 1'b0);
    wait_idle();

    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
